@@ design/bspf_pkg.sv @@
`default_nettype none

package bspf_pkg;

  // Frame geometry and store sizes
  localparam int LINE_WIDTH      = 240;
  localparam int LINE_COUNT      = 160;
  localparam int VIDEO_HALFWORDS = 49152;
  localparam int PAL_ENTRIES     = 512;

  localparam int VID_AW = $clog2(VIDEO_HALFWORDS);
  localparam int PAL_AW = $clog2(PAL_ENTRIES);

  // Line and column fields are 8 bits wide
  localparam int POS_MAX = 255;
  localparam int LINE_W  = $clog2(LINE_COUNT > POS_MAX + 1 ? LINE_COUNT : POS_MAX + 1);

  localparam int PAGE_OFFSET = 'hA000;

  // Linear offset line*width+column, and the byte address with the page added
  localparam int LC_W  = $clog2(POS_MAX * LINE_WIDTH + POS_MAX + 1);
  localparam int BA_W  = $clog2(POS_MAX * LINE_WIDTH + POS_MAX + PAGE_OFFSET + 1);
  localparam int IDX_W = (BA_W > 17) ? BA_W : 17;

  localparam logic [15:0] WHITE      = 16'hFFFF;
  localparam logic [4:0]  LAYER_MASK = 5'h1F;
  localparam int          BITMAP_BIT = 2;

  localparam int CFG_DW = 5;

  localparam logic [2:0] MODE_DIRECT   = 3'd3;
  localparam logic [2:0] MODE_PALETTED = 3'd4;

  typedef enum logic [1:0] {
    OP_VID_WR = 2'd0,
    OP_PAL_WR = 2'd1,
    OP_FETCH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_PAGE   = 2'd1,
    CFG_BLANK  = 2'd2,
    CFG_LAYERS = 2'd3
  } cfg_e;

  // How a fetch resolves, settled when the item is accepted
  typedef enum logic [2:0] {
    KIND_BLANK,
    KIND_BACKDROP,
    KIND_DIRECT,
    KIND_PALETTED,
    KIND_OFF,
    KIND_UNSUP
  } kind_e;

  typedef struct packed {
    logic [2:0] video_mode;
    logic       frame_page;
    logic       force_blank;
    logic [4:0] layer_enables;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    op_e               op;
    kind_e             kind;
    logic              byte_sel;
    logic              vid_ok;
    logic [VID_AW-1:0] vid_addr;
    logic              pal_ok;
    logic [PAL_AW-1:0] pal_idx;
    logic [15:0]       wdata;
  } stage_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        drawn;
    logic        unsupported_mode;
  } res_t;

endpackage

`default_nettype wire

@@ design/bspf_if.sv @@
`default_nettype none

interface bspf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] mem_index;
  logic [15:0] write_data;
  logic [7:0]  line;
  logic [7:0]  column;

  modport source (output valid, operation, mem_index, write_data, line, column,
                  input ready);
  modport sink (input valid, operation, mem_index, write_data, line, column,
                output ready);
endinterface

interface bspf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic        drawn;
  logic        unsupported_mode;

  modport source (output valid, pixel, drawn, unsupported_mode, input ready);
  modport sink (input valid, pixel, drawn, unsupported_mode, output ready);
endinterface

`default_nettype wire

@@ design/bspf_ram.sv @@
`default_nettype none

module bspf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/bspf_addr_stage.sv @@
`default_nettype none

module bspf_addr_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [1:0]           operation_i,
  input  wire logic [15:0]          mem_index_i,
  input  wire logic [15:0]          write_data_i,
  input  wire logic [7:0]           line_i,
  input  wire logic [7:0]           column_i,
  input  wire bspf_pkg::cfg_t       cfg_i,
  output bspf_pkg::stage_t          stage_o
);

  logic [bspf_pkg::LC_W-1:0]  lin_off;
  logic [bspf_pkg::BA_W-1:0]  byte_addr;
  logic [bspf_pkg::IDX_W-1:0] hw_idx;
  logic                       bitmap_on;
  bspf_pkg::op_e              op;
  bspf_pkg::kind_e            kind;
  bspf_pkg::stage_t           stage_d, stage_q;

  assign op        = bspf_pkg::op_e'(operation_i);
  assign bitmap_on = cfg_i.layer_enables[bspf_pkg::BITMAP_BIT];

  always_comb begin
    lin_off   = bspf_pkg::LC_W'(line_i) * bspf_pkg::LC_W'(bspf_pkg::LINE_WIDTH)
              + bspf_pkg::LC_W'(column_i);
    byte_addr = bspf_pkg::BA_W'(lin_off)
              + (cfg_i.frame_page ? bspf_pkg::BA_W'(bspf_pkg::PAGE_OFFSET)
                                  : bspf_pkg::BA_W'(0));
    if (op == bspf_pkg::OP_VID_WR) begin
      hw_idx = bspf_pkg::IDX_W'(mem_index_i);
    end else if (cfg_i.video_mode == bspf_pkg::MODE_PALETTED) begin
      hw_idx = bspf_pkg::IDX_W'(byte_addr >> 1);
    end else begin
      hw_idx = bspf_pkg::IDX_W'(lin_off);
    end
  end

  always_comb begin
    if (cfg_i.force_blank) begin
      kind = bspf_pkg::KIND_BLANK;
    end else if ((cfg_i.layer_enables & bspf_pkg::LAYER_MASK) == '0) begin
      kind = bspf_pkg::KIND_BACKDROP;
    end else if (cfg_i.video_mode == bspf_pkg::MODE_DIRECT) begin
      kind = bitmap_on ? bspf_pkg::KIND_DIRECT : bspf_pkg::KIND_OFF;
    end else if (cfg_i.video_mode == bspf_pkg::MODE_PALETTED) begin
      kind = bitmap_on ? bspf_pkg::KIND_PALETTED : bspf_pkg::KIND_OFF;
    end else begin
      kind = bspf_pkg::KIND_UNSUP;
    end
  end

  always_comb begin
    stage_d.valid    = valid_i;
    stage_d.op       = op;
    stage_d.kind     = kind;
    stage_d.byte_sel = byte_addr[0];
    stage_d.vid_ok   = hw_idx < bspf_pkg::IDX_W'(bspf_pkg::VIDEO_HALFWORDS);
    stage_d.vid_addr = hw_idx[bspf_pkg::VID_AW-1:0];
    stage_d.pal_ok   = 17'(mem_index_i) < 17'(bspf_pkg::PAL_ENTRIES);
    stage_d.pal_idx  = mem_index_i[bspf_pkg::PAL_AW-1:0];
    stage_d.wdata    = write_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ design/bspf_out_skid.sv @@
`default_nettype none

module bspf_out_skid (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  input  wire bspf_pkg::res_t res_i,
  output logic                en_o,
  bspf_out_if.source          out
);

  logic           out_valid_q, skid_valid_q;
  bspf_pkg::res_t out_q, skid_q;

  // The pipeline moves only while the skid slot is free
  assign en_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      if (res_valid_i) begin
        if (!out_valid_q || out.ready) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out.ready) begin
        out_valid_q <= 1'b0;
      end
    end else if (out.ready) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      if (res_valid_i) begin
        if (!out_valid_q || out.ready) begin
          out_q <= res_i;
        end else begin
          skid_q <= res_i;
        end
      end
    end else if (out.ready) begin
      out_q <= skid_q;
    end
  end

  assign out.valid            = out_valid_q;
  assign out.pixel            = out_q.pixel;
  assign out.drawn            = out_q.drawn;
  assign out.unsupported_mode = out_q.unsupported_mode;

endmodule

`default_nettype wire

@@ design/bitmap_scanline_pixel_fetch_core.sv @@
// Channel   Dir  Handshake      Carries
// in        in   valid/ready    operation, mem_index, write_data, line, column
// out       out  valid/ready    pixel, drawn, unsupported_mode
// cfg       in   cfg_we_i       cfg_index_i selects the register, cfg_data_i
//
// One item a cycle while the skid slot is free; a fetch passes every stage below before it shows.
// Stages: address multiply, video RAM read, palette RAM read, output register.
// Writes take effect in the stage that reads the same store, so order holds.
// A two-entry output buffer freezes the whole pipeline only when both are full.
// Reset clears valid bits, config and the stage A and B registers; the RAMs hold garbage until written.
`default_nettype none

module bitmap_scanline_pixel_fetch_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [bspf_pkg::CFG_DW-1:0] cfg_data_i,
  bspf_in_if.sink                          in,
  bspf_out_if.source                       out
);

  logic                         en;
  bspf_pkg::cfg_t               cfg_q;
  bspf_pkg::stage_t             a_st, b_q;
  logic [15:0]                  vid_rd, pal_rd;
  logic                         vid_we, pal_we;
  logic [7:0]                   pix_byte;
  logic [bspf_pkg::PAL_AW-1:0]  pal_addr;
  logic                         c_valid_q, c_vid_ok_q;
  bspf_pkg::kind_e              c_kind_q;
  logic [15:0]                  c_vid_q;
  bspf_pkg::res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bspf_pkg::cfg_e'(cfg_index_i))
        bspf_pkg::CFG_MODE:   cfg_q.video_mode    <= cfg_data_i[2:0];
        bspf_pkg::CFG_PAGE:   cfg_q.frame_page    <= cfg_data_i[0];
        bspf_pkg::CFG_BLANK:  cfg_q.force_blank   <= cfg_data_i[0];
        bspf_pkg::CFG_LAYERS: cfg_q.layer_enables <= cfg_data_i[4:0];
      endcase
    end
  end

  assign in.ready = en;

  bspf_addr_stage u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in.valid),
    .operation_i (in.operation),
    .mem_index_i (in.mem_index),
    .write_data_i(in.write_data),
    .line_i      (in.line),
    .column_i    (in.column),
    .cfg_i       (cfg_q),
    .stage_o     (a_st)
  );

  assign vid_we = en && a_st.valid && (a_st.op == bspf_pkg::OP_VID_WR) && a_st.vid_ok;

  bspf_ram #(
    .WIDTH(16),
    .DEPTH(bspf_pkg::VIDEO_HALFWORDS)
  ) u_vid_ram (
    .clk_i  (clk_i),
    .we_i   (vid_we),
    .re_i   (en),
    .addr_i (a_st.vid_addr),
    .wdata_i(a_st.wdata),
    .rdata_o(vid_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en) begin
      b_q <= a_st;
    end
  end

  // Reads past video memory give index 0, hence the backdrop entry
  always_comb begin
    pix_byte = '0;
    if (b_q.vid_ok) begin
      pix_byte = b_q.byte_sel ? vid_rd[15:8] : vid_rd[7:0];
    end
    if (b_q.op == bspf_pkg::OP_PAL_WR) begin
      pal_addr = b_q.pal_idx;
    end else if (b_q.kind == bspf_pkg::KIND_PALETTED) begin
      pal_addr = bspf_pkg::PAL_AW'(pix_byte);
    end else begin
      pal_addr = '0;
    end
  end

  assign pal_we = en && b_q.valid && (b_q.op == bspf_pkg::OP_PAL_WR) && b_q.pal_ok;

  bspf_ram #(
    .WIDTH(16),
    .DEPTH(bspf_pkg::PAL_ENTRIES)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .re_i   (en),
    .addr_i (pal_addr),
    .wdata_i(b_q.wdata),
    .rdata_o(pal_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_q.valid && (b_q.op == bspf_pkg::OP_FETCH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_kind_q   <= b_q.kind;
      c_vid_ok_q <= b_q.vid_ok;
      c_vid_q    <= vid_rd;
    end
  end

  always_comb begin
    res = '0;
    case (c_kind_q)
      bspf_pkg::KIND_BLANK: begin
        res.pixel = bspf_pkg::WHITE;
        res.drawn = 1'b1;
      end
      bspf_pkg::KIND_BACKDROP, bspf_pkg::KIND_PALETTED: begin
        res.pixel = pal_rd;
        res.drawn = 1'b1;
      end
      bspf_pkg::KIND_DIRECT: begin
        res.pixel = c_vid_ok_q ? c_vid_q : 16'h0000;
        res.drawn = 1'b1;
      end
      bspf_pkg::KIND_UNSUP: res.unsupported_mode = 1'b1;
      default: res = '0;
    endcase
  end

  bspf_out_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(c_valid_q && en),
    .res_i      (res),
    .en_o       (en),
    .out        (out)
  );

  // A frozen pipeline always has a result on show
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> out.valid)
    else $error("pipeline frozen with no result on the output");

  a_unsup_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out.valid && out.unsupported_mode |-> !out.drawn && (out.pixel == 16'h0000))
    else $error("unsupported mode result carries a pixel");

  a_fetch_reaches_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in.valid && in.ready && (in.operation == bspf_pkg::OP_FETCH)) ##1 en ##1 en
      |=> c_valid_q)
    else $error("fetch item lost in the pipeline");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && b_q.valid && (b_q.op != bspf_pkg::OP_FETCH) |=> !c_valid_q)
    else $error("write item produced a result");

endmodule

`default_nettype wire
